### design/humidity_sensor_frame_checker_assert.svh
// ----------------------------------------------------------------------------
// humidity_sensor_frame_checker_assert.svh
// assertion macros used by the frame checker assertion module hsfc_checker
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_FRAME_CHECKER_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_CHECKER_ASSERT_SVH

// same-cycle implication
`define HSFC_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("hsfc assertion failed");

// next-cycle implication
`define HSFC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("hsfc assertion failed");

`endif

### design/hsfc_pkg.sv
// ----------------------------------------------------------------------------
// hsfc_pkg
// types, constants and helper functions of the sensor frame checker
// ----------------------------------------------------------------------------
package hsfc_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_LAST  = 3'd5;

    localparam logic [14:0] T_SCALE  = 15'd17500;
    localparam logic [13:0] H_SCALE  = 14'd10000;
    localparam logic [15:0] T_OFFSET = 16'd4500;
    localparam logic [16:0] DIV_D    = 17'd65535;

    localparam logic signed [14:0] T_MIN = -15'sd4500;
    localparam logic signed [14:0] T_MAX = 15'sd13000;
    localparam logic [13:0]        H_MAX = 14'd10000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CRC_ERR   = 2'd1,
        ST_NO_SENSOR = 2'd2
    } t_status;

    // crc-8, poly 0x31, msb first
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^31, one compare as correction
    function automatic logic [14:0] div65535(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] r0;
        q0 = x[30:16];
        r0 = {1'b0, x[15:0]} + {2'b00, q0};
        return q0 + {14'd0, (r0 >= DIV_D)};
    endfunction

endpackage

### design/hsfc_if.sv
// ----------------------------------------------------------------------------
// hsfc_if
// valid/ready channels of the sensor frame checker
// ----------------------------------------------------------------------------
interface hsfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface hsfc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               valid_res;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;

    modport source (output valid, output status, output valid_res,
                    output temperature_centi, output humidity_centi, input ready);
    modport sink (input valid, input status, input valid_res,
                  input temperature_centi, input humidity_centi, output ready);
endinterface

interface hsfc_cfg_if;
    logic valid;
    logic ready;
    logic sensor_present;

    modport source (output valid, output sensor_present, input ready);
    modport sink (input valid, input sensor_present, output ready);
endinterface

### design/humidity_sensor_frame_checker.sv
// ----------------------------------------------------------------------------
// humidity_sensor_frame_checker
// crc-8 check and scaling of six-byte temperature/humidity frames
// ----------------------------------------------------------------------------
// i_in carries one frame byte per beat plus a frame-start flag; frame order is
// temperature high, low, crc, humidity high, low, crc. i_cfg writes the
// sensor_present bit and is always ready. o_out gives one beat per frame, on
// the sixth byte: status, valid_res and the scaled values (zero unless ok).
// One byte is taken every cycle while i_in.ready is high. The datapath is an
// input register, a stage holding the crc check and the two scaling products,
// and the output register; a result passes through each of them in turn.
// Bytes that close no frame leave no result and never enter the product stage.
// When o_out is stalled the output register holds its beat while bytes keep
// flowing until the next frame's result waits in the product stage and one
// more byte sits in the input register; then i_in.ready drops. Reset
// (synchronous, active low) empties all stages, sets the byte position to
// zero, the crc to 0xFF and sensor_present to 0.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hsfc_in_if.sink          i_in,
    hsfc_cfg_if.sink         i_cfg,
    hsfc_out_if.source       o_out
);
    import hsfc_pkg::*;

    logic               r_present;

    logic               r_in_vld;
    logic [7:0]         r_in_byte;
    logic               r_in_start;

    logic [2:0]         r_pos,      n_pos;
    logic [7:0]         r_crc,      n_crc;
    logic [15:0]        r_raw_t,    n_raw_t;
    logic [7:0]         r_hum_hi,   n_hum_hi;
    logic [7:0]         r_hum_lo,   n_hum_lo;
    logic               r_crc_fail, n_crc_fail;

    logic               r_s1_vld;
    t_status            r_s1_status, n_s1_status;
    logic               r_s1_ok,     n_s1_ok;
    logic [30:0]        r_s1_tprod,  n_s1_tprod;
    logic [29:0]        r_s1_hprod,  n_s1_hprod;

    logic               r_out_vld;
    t_status            r_out_status;
    logic               r_out_ok;
    logic signed [14:0] r_out_temp,  n_out_temp;
    logic [13:0]        r_out_hum,   n_out_hum;

    logic        out_free, s1_adv, s1_ready, s0_adv, s0_res;
    logic [2:0]  pos;
    logic [7:0]  crc_src, crc_fed;
    logic        res_bad;
    logic [14:0] t_q, h_q;
    logic [15:0] t_ext;

    assign i_cfg.ready = 1'b1;

    // handshake chain
    assign out_free = !r_out_vld || o_out.ready;
    assign s1_adv   = r_s1_vld && out_free;
    assign s1_ready = !r_s1_vld || out_free;
    assign s0_adv   = r_in_vld && s1_ready;
    assign i_in.ready = !r_in_vld || s0_adv;

    // frame state and result products
    always_comb begin
        pos     = r_in_start ? POS_T_HI : r_pos;
        crc_src = (pos == POS_T_HI) ? CRC_INIT : r_crc;
        crc_fed = crc_feed(crc_src, r_in_byte);
        res_bad = r_crc_fail || (r_crc != r_in_byte);
        s0_res  = 1'b0;

        n_pos      = (pos >= POS_LAST) ? POS_T_HI : pos + 3'd1;
        n_crc      = r_crc;
        n_raw_t    = r_raw_t;
        n_hum_hi   = r_hum_hi;
        n_hum_lo   = r_hum_lo;
        n_crc_fail = r_crc_fail;

        n_s1_status = ST_OK;
        n_s1_ok     = 1'b0;
        n_s1_tprod  = {16'd0, T_SCALE} * {15'd0, r_raw_t};
        n_s1_hprod  = {16'd0, H_SCALE} * {14'd0, r_hum_hi, r_hum_lo};

        case (pos)
            POS_T_HI: begin
                n_crc_fail = 1'b0;
                n_crc      = crc_fed;
                n_raw_t    = {r_in_byte, 8'd0};
            end
            POS_T_LO: begin
                n_crc   = crc_fed;
                n_raw_t = {r_raw_t[15:8], r_in_byte};
            end
            POS_T_CRC: begin
                if (r_crc != r_in_byte) begin
                    n_crc_fail = 1'b1;
                end
                n_crc = CRC_INIT;
            end
            POS_H_HI: begin
                n_crc    = crc_fed;
                n_hum_hi = r_in_byte;
            end
            POS_H_LO: begin
                n_crc    = crc_fed;
                n_hum_lo = r_in_byte;
            end
            default: begin
                s0_res     = 1'b1;
                n_crc_fail = res_bad;
                n_crc      = CRC_INIT;
                if (!r_present) begin
                    n_s1_status = ST_NO_SENSOR;
                end else if (res_bad) begin
                    n_s1_status = ST_CRC_ERR;
                end else begin
                    n_s1_ok = 1'b1;
                end
            end
        endcase
    end

    // divide by 65535 and offset
    always_comb begin
        t_q   = div65535(r_s1_tprod);
        h_q   = div65535({1'b0, r_s1_hprod});
        t_ext = {1'b0, t_q} - T_OFFSET;
        n_out_temp = r_s1_ok ? signed'(t_ext[14:0]) : '0;
        n_out_hum  = r_s1_ok ? h_q[13:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= 1'b0;
            r_in_vld   <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pos      <= POS_T_HI;
            r_crc      <= CRC_INIT;
            r_raw_t    <= '0;
            r_hum_hi   <= '0;
            r_hum_lo   <= '0;
            r_crc_fail <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_present <= i_cfg.sensor_present;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (s0_adv) begin
                r_in_vld <= 1'b0;
            end
            if (s0_adv) begin
                r_pos      <= n_pos;
                r_crc      <= n_crc;
                r_raw_t    <= n_raw_t;
                r_hum_hi   <= n_hum_hi;
                r_hum_lo   <= n_hum_lo;
                r_crc_fail <= n_crc_fail;
            end
            if (s0_adv && s0_res) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.rx_byte;
            r_in_start <= i_in.frame_start;
        end
        if (s0_adv && s0_res) begin
            r_s1_status <= n_s1_status;
            r_s1_ok     <= n_s1_ok;
            r_s1_tprod  <= n_s1_tprod;
            r_s1_hprod  <= n_s1_hprod;
        end
        if (s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_ok     <= r_s1_ok;
            r_out_temp   <= n_out_temp;
            r_out_hum    <= n_out_hum;
        end
    end

    assign o_out.valid             = r_out_vld;
    assign o_out.status            = r_out_status;
    assign o_out.valid_res         = r_out_ok;
    assign o_out.temperature_centi = r_out_temp;
    assign o_out.humidity_centi    = r_out_hum;

endmodule

### design/hsfc_checker.sv
// ----------------------------------------------------------------------------
// hsfc_checker
// port-level assertions on the result channel of the frame checker
// ----------------------------------------------------------------------------
`include "humidity_sensor_frame_checker_assert.svh"

module hsfc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready,
    input  logic [1:0]         i_status,
    input  logic               i_valid_res,
    input  logic signed [14:0] i_temp,
    input  logic [13:0]        i_hum
);
    import hsfc_pkg::*;

    `HSFC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_status) && $stable(i_valid_res) && $stable(i_temp) && $stable(i_hum))

    `HSFC_ASSERT_IMPLY(a_ok_status, i_clk, i_rst_n, i_valid && i_valid_res, i_status == ST_OK)

    `HSFC_ASSERT_IMPLY(a_zero_on_fail, i_clk, i_rst_n, i_valid && !i_valid_res, i_temp == 15'sd0 && i_hum == 14'd0 && i_status != ST_OK)

    `HSFC_ASSERT_IMPLY(a_range, i_clk, i_rst_n, i_valid && i_valid_res, i_temp >= T_MIN && i_temp <= T_MAX && i_hum <= H_MAX)

endmodule

bind humidity_sensor_frame_checker hsfc_checker u_hsfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_status    (o_out.status),
    .i_valid_res (o_out.valid_res),
    .i_temp      (o_out.temperature_centi),
    .i_hum       (o_out.humidity_centi)
);

### bench/hsfc_bench_pkg.sv
// ----------------------------------------------------------------------------
// hsfc_bench_pkg
// crc helper and result record shared by the frame checker bench
// ----------------------------------------------------------------------------
package hsfc_bench_pkg;

    import hsfc_pkg::*;

    typedef struct {
        t_status            status;
        logic               valid_res;
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
    } frame_result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc ^ data;
        repeat (8) begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

endpackage

### bench/hsfc_frame_scoreboard.sv
// ----------------------------------------------------------------------------
// hsfc_frame_scoreboard
// watches the frame checker channels, predicts each frame result and compares
// ----------------------------------------------------------------------------
// Every accepted byte runs through a bench-side copy of the frame state:
// byte position, running crc, captured words and the crc error flag. The
// sixth byte of a frame queues its expected result; every result beat is
// compared field by field against the oldest queued frame.
// ----------------------------------------------------------------------------
module hsfc_frame_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    hsfc_in_if   i_in,
    hsfc_cfg_if  i_cfg,
    hsfc_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    import hsfc_pkg::*;
    import hsfc_bench_pkg::*;

    logic          present;
    logic [2:0]    frame_pos;
    logic [7:0]    crc_acc;
    logic [15:0]   temp_word;
    logic [7:0]    hum_hi;
    logic [7:0]    hum_lo;
    logic          crc_bad;
    frame_result_t expected_frames[$];

    task automatic predict_byte(input logic [7:0] data, input logic first);
        logic [2:0]    pos;
        logic [31:0]   scaled;
        int            temp_val;
        frame_result_t res;
        pos = first ? POS_T_HI : frame_pos;
        case (pos)
            POS_T_HI: begin
                crc_bad   = 1'b0;
                crc_acc   = crc8_update(CRC_INIT, data);
                temp_word = {data, 8'h00};
            end
            POS_T_LO: begin
                crc_acc        = crc8_update(crc_acc, data);
                temp_word[7:0] = data;
            end
            POS_T_CRC: begin
                if (crc_acc != data) crc_bad = 1'b1;
                crc_acc = CRC_INIT;
            end
            POS_H_HI: begin
                crc_acc = crc8_update(crc_acc, data);
                hum_hi  = data;
            end
            POS_H_LO: begin
                crc_acc = crc8_update(crc_acc, data);
                hum_lo  = data;
            end
            default: begin
                if (crc_acc != data) crc_bad = 1'b1;
                res.status            = ST_OK;
                res.valid_res         = 1'b0;
                res.temperature_centi = '0;
                res.humidity_centi    = '0;
                if (!present) begin
                    res.status = ST_NO_SENSOR;
                end else if (crc_bad) begin
                    res.status = ST_CRC_ERR;
                end else begin
                    res.valid_res         = 1'b1;
                    scaled                = 32'd17500 * {16'd0, temp_word};
                    temp_val              = int'(scaled / 32'd65535) - 4500;
                    res.temperature_centi = temp_val[14:0];
                    scaled                = 32'd10000 * {16'd0, hum_hi, hum_lo};
                    res.humidity_centi    = 14'(scaled / 32'd65535);
                end
                expected_frames.push_back(res);
                crc_acc = CRC_INIT;
            end
        endcase
        frame_pos = (pos >= POS_LAST) ? POS_T_HI : pos + 3'd1;
    endtask

    task automatic check_result();
        frame_result_t want;
        if (expected_frames.size() == 0) begin
            $error("result beat with no frame pending: status %0d", i_res.status);
            o_fail_count++;
        end else begin
            want = expected_frames.pop_front();
            if (i_res.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, i_res.status);
                o_fail_count++;
            end
            if (i_res.valid_res !== want.valid_res) begin
                $error("valid_res expected %0d actual %0d", want.valid_res, i_res.valid_res);
                o_fail_count++;
            end
            if (i_res.temperature_centi !== want.temperature_centi) begin
                $error("temperature_centi expected %0d actual %0d",
                       want.temperature_centi, i_res.temperature_centi);
                o_fail_count++;
            end
            if (i_res.humidity_centi !== want.humidity_centi) begin
                $error("humidity_centi expected %0d actual %0d",
                       want.humidity_centi, i_res.humidity_centi);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            present      = 1'b0;
            frame_pos    = POS_T_HI;
            crc_acc      = CRC_INIT;
            temp_word    = '0;
            hum_hi       = '0;
            hum_lo       = '0;
            crc_bad      = 1'b0;
            expected_frames.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_cfg.valid === 1'b1 && i_cfg.ready === 1'b1) begin
                present = i_cfg.sensor_present;
            end
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                check_result();
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                predict_byte(i_in.rx_byte, i_in.frame_start);
            end
            o_pending = expected_frames.size();
        end
    end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the sensor frame checker
// ----------------------------------------------------------------------------
// A short directed run covers the sensor-absent status, the word extremes,
// position wrap without a start flag, a dropped partial frame and a bad
// temperature crc. Random phases follow with the sensor present, absent and
// present again: mostly well-formed frames with random words and occasional
// corrupted crcs, mixed with stray bytes and misplaced start flags. Both
// channels idle at random, with one long output hold-off to fill the block.
// ----------------------------------------------------------------------------
module testbench;

    import hsfc_pkg::*;
    import hsfc_bench_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    logic clk;
    logic rst_n;
    logic hold_req;
    logic steady;
    int   bytes_sent;
    int   cycle_count;
    int   fail_count;
    int   pending;

    hsfc_in_if  in_ch ();
    hsfc_out_if out_ch ();
    hsfc_cfg_if cfg_ch ();

    humidity_sensor_frame_checker u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    hsfc_frame_scoreboard u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic first);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.rx_byte     <= data;
        in_ch.frame_start <= first;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        bytes_sent++;
        steady = ((bytes_sent >> 7) % 4) == 3;
    endtask

    task automatic send_frame(input logic [15:0] temp_raw, input logic [15:0] hum_raw,
                              input logic temp_ok, input logic hum_ok, input logic first);
        logic [7:0] temp_crc;
        logic [7:0] hum_crc;
        temp_crc = crc8_update(crc8_update(CRC_INIT, temp_raw[15:8]), temp_raw[7:0]);
        hum_crc  = crc8_update(crc8_update(CRC_INIT, hum_raw[15:8]), hum_raw[7:0]);
        if (!temp_ok) temp_crc ^= 8'($urandom_range(1, 255));
        if (!hum_ok) hum_crc ^= 8'($urandom_range(1, 255));
        send_byte(temp_raw[15:8], first);
        send_byte(temp_raw[7:0], 1'b0);
        send_byte(temp_crc, 1'b0);
        send_byte(hum_raw[15:8], 1'b0);
        send_byte(hum_raw[7:0], 1'b0);
        send_byte(hum_crc, 1'b0);
    endtask

    // drop valid and wait until every queued frame has come out
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_presence(input logic value);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.sensor_present <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(input int target);
        int n;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 5);
                repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end else begin
                send_frame(pick_word(), pick_word(), $urandom_range(0, 4) != 0,
                           $urandom_range(0, 4) != 0, $urandom_range(0, 9) < 8);
            end
        end
    endtask

    initial begin
        rst_n                 <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.rx_byte         <= '0;
        in_ch.frame_start     <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.sensor_present <= 1'b0;
        hold_req   = 1'b0;
        steady     = 1'b0;
        bytes_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sensor absent out of reset
        send_frame(16'h6A3C, 16'h8E21, 1'b1, 1'b1, 1'b1);
        drain();
        write_presence(1'b1);
        send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        // no start flag, relies on position wrap
        send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0);
        // partial frame dropped by the next start flag
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_frame(16'h1234, 16'h5678, 1'b0, 1'b1, 1'b1);
        drain();

        hold_req = 1'b1;
        run_random(bytes_sent + 800);
        drain();
        write_presence(1'b0);
        run_random(bytes_sent + 350);
        drain();
        write_presence(1'b1);
        run_random(bytes_sent + 600);
        drain();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : receiver
        int stall;
        out_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                stall = steady ? 0 : pick_gap();
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
